@@ hw/rtl/wsd_pkg.sv @@
package wsd_pkg;

    localparam int FRAME_LEN_W = 24;
    localparam logic [FRAME_LEN_W-1:0] MAX_FRAME_RESET = FRAME_LEN_W'(15728640);
    localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_SAT = '1;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERSIZE = 2'd1;
    localparam logic [1:0] ERR_EMPTY    = 2'd2;

    localparam logic [3:0] OP_TEXT   = 4'd1;
    localparam logic [3:0] OP_BINARY = 4'd2;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    typedef struct packed {
        logic [1:0]             kind;
        logic                   fin_flag;
        logic [3:0]             opcode;
        logic                   was_masked;
        logic [FRAME_LEN_W-1:0] frame_length;
        logic [7:0]             payload_byte;
        logic                   last;
        logic [1:0]             error_code;
    } wsd_result_t;

endpackage

@@ hw/rtl/wsd_if.sv @@
interface wsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface wsd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [wsd_pkg::FRAME_LEN_W-1:0] size_limit;

    modport source (output valid, output size_limit, input ready);
    modport sink (input valid, input size_limit, output ready);
endinterface

interface wsd_res_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     kind;
    logic                           fin_flag;
    logic [3:0]                     opcode;
    logic                           was_masked;
    logic [wsd_pkg::FRAME_LEN_W-1:0] frame_length;
    logic [7:0]                     payload_byte;
    logic                           last;
    logic [1:0]                     error_code;

    modport source (output valid, output kind, output fin_flag, output opcode,
                    output was_masked, output frame_length, output payload_byte,
                    output last, output error_code, input ready);
    modport sink (input valid, input kind, input fin_flag, input opcode,
                  input was_masked, input frame_length, input payload_byte,
                  input last, input error_code, output ready);
endinterface

@@ hw/rtl/wsd_parser.sv @@
module wsd_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rx_valid,
    input  logic [7:0]                  rx_byte,
    input  logic                        rx_ready,
    input  logic                        cfg_valid,
    input  logic [wsd_pkg::FRAME_LEN_W-1:0] cfg_data,
    output logic                        res_load,
    output wsd_pkg::wsd_result_t        res_data
);
    import wsd_pkg::*;

    typedef enum logic [4:0] {
        PH_HDR0    = 5'b00001,
        PH_HDR1    = 5'b00010,
        PH_EXTLEN  = 5'b00100,
        PH_KEY     = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic                   fin_reg, fin_next;
    logic [3:0]             op_reg, op_next;
    logic                   key_en_reg, key_en_next;
    logic [FRAME_LEN_W-1:0] len_reg, len_next;
    logic                   ovf_reg, ovf_next;
    logic [3:0]             cnt_reg, cnt_next;
    logic [31:0]            key_reg, key_next;
    logic [1:0]             kidx_reg, kidx_next;
    logic [FRAME_LEN_W-1:0] left_reg, left_next;
    logic                   err_reg, err_next;
    logic [FRAME_LEN_W-1:0] max_reg;

    logic       accept;
    logic       len_done;
    logic       hdr_done;
    logic       oversize;
    logic       empty_data;
    logic [7:0] key_byte;

    assign accept = rx_valid && rx_ready;

    always_comb
    begin
        case (kidx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        fin_next    = fin_reg;
        op_next     = op_reg;
        key_en_next = key_en_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        cnt_next    = cnt_reg;
        key_next    = key_reg;
        kidx_next   = kidx_reg;
        left_next   = left_reg;
        err_next    = err_reg;
        len_done    = 1'b0;
        hdr_done    = 1'b0;
        oversize    = 1'b0;
        empty_data  = 1'b0;
        res_load    = 1'b0;
        res_data    = '0;

        if (accept && !err_reg)
        begin
            case (phase_reg)
                PH_HDR1:
                begin
                    key_en_next = rx_byte[7];
                    ovf_next    = 1'b0;
                    if (rx_byte[6:0] == LEN7_EXT16)
                    begin
                        len_next   = '0;
                        cnt_next   = EXT16_BYTES;
                        phase_next = PH_EXTLEN;
                    end
                    else if (rx_byte[6:0] == LEN7_EXT64)
                    begin
                        len_next   = '0;
                        cnt_next   = EXT64_BYTES;
                        phase_next = PH_EXTLEN;
                    end
                    else
                    begin
                        len_next = {{(FRAME_LEN_W-7){1'b0}}, rx_byte[6:0]};
                        len_done = 1'b1;
                    end
                end
                PH_EXTLEN:
                begin
                    // bytes pushed past the top only ever make the length too big
                    len_next = {len_reg[FRAME_LEN_W-9:0], rx_byte};
                    ovf_next = ovf_reg | (|len_reg[FRAME_LEN_W-1:FRAME_LEN_W-8]);
                    cnt_next = cnt_reg - 4'd1;
                    len_done = (cnt_reg == 4'd1);
                end
                PH_KEY:
                begin
                    key_next = {key_reg[23:0], rx_byte};
                    cnt_next = cnt_reg - 4'd1;
                    hdr_done = (cnt_reg == 4'd1);
                end
                PH_PAYLOAD:
                begin
                    kidx_next = kidx_reg + 2'd1;
                    left_next = left_reg - FRAME_LEN_W'(1);
                    res_load  = 1'b1;
                    res_data.kind         = KIND_PAYLOAD;
                    res_data.fin_flag     = fin_reg;
                    res_data.opcode       = op_reg;
                    res_data.was_masked   = key_en_reg;
                    res_data.frame_length = len_reg;
                    res_data.payload_byte = rx_byte ^ (key_en_reg ? key_byte : 8'd0);
                    res_data.last         = (left_reg == FRAME_LEN_W'(1));
                    res_data.error_code   = ERR_NONE;
                    if (left_reg == FRAME_LEN_W'(1))
                    begin
                        phase_next = PH_HDR0;
                    end
                end
                default:
                begin
                    fin_next   = rx_byte[7];
                    op_next    = rx_byte[3:0];
                    phase_next = PH_HDR1;
                end
            endcase
        end

        if (len_done)
        begin
            oversize   = ovf_next || (len_next > max_reg);
            empty_data = (len_next == '0) && (op_reg inside {OP_TEXT, OP_BINARY});
            if (oversize || empty_data)
            begin
                res_load = 1'b1;
                res_data.kind         = KIND_ERROR;
                res_data.fin_flag     = fin_reg;
                res_data.opcode       = op_reg;
                res_data.was_masked   = key_en_next;
                res_data.frame_length = ovf_next ? FRAME_LEN_SAT : len_next;
                res_data.payload_byte = 8'd0;
                res_data.last         = 1'b0;
                res_data.error_code   = oversize ? ERR_OVERSIZE : ERR_EMPTY;
                err_next   = 1'b1;
                phase_next = PH_HDR0;
            end
            else if (key_en_next)
            begin
                cnt_next   = KEY_BYTES;
                key_next   = '0;
                phase_next = PH_KEY;
            end
            else
            begin
                key_next = '0;
                hdr_done = 1'b1;
            end
        end

        if (hdr_done)
        begin
            res_load = 1'b1;
            res_data.kind         = KIND_HEADER;
            res_data.fin_flag     = fin_reg;
            res_data.opcode       = op_reg;
            res_data.was_masked   = key_en_next;
            res_data.frame_length = len_next;
            res_data.payload_byte = 8'd0;
            res_data.last         = (len_next == '0);
            res_data.error_code   = ERR_NONE;
            kidx_next = 2'd0;
            if (len_next == '0)
            begin
                phase_next = PH_HDR0;
            end
            else
            begin
                left_next  = len_next;
                phase_next = PH_PAYLOAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            fin_reg    <= 1'b0;
            op_reg     <= 4'd0;
            key_en_reg <= 1'b0;
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            cnt_reg    <= 4'd0;
            key_reg    <= '0;
            kidx_reg   <= 2'd0;
            left_reg   <= '0;
            err_reg    <= 1'b0;
            max_reg    <= MAX_FRAME_RESET;
        end
        else
        begin
            phase_reg  <= phase_next;
            fin_reg    <= fin_next;
            op_reg     <= op_next;
            key_en_reg <= key_en_next;
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            cnt_reg    <= cnt_next;
            key_reg    <= key_next;
            kidx_reg   <= kidx_next;
            left_reg   <= left_next;
            err_reg    <= err_next;
            if (cfg_valid)
            begin
                max_reg <= cfg_data;
            end
        end
    end

endmodule

@@ hw/rtl/wsd_out_reg.sv @@
module wsd_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  wsd_pkg::wsd_result_t din,
    input  logic                 take,
    output logic                 valid,
    output wsd_pkg::wsd_result_t dout,
    output logic                 ready
);
    import wsd_pkg::*;

    logic        valid_reg, valid_next;
    wsd_result_t data_reg;

    // slot is free when empty or drained in this cycle
    assign ready = !valid_reg || take;
    assign valid = valid_reg;
    assign dout  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= din;
        end
    end

endmodule

@@ hw/rtl/websocket_frame_deframer.sv @@
// Results are registered, shown in the cycle after the byte that completes them.
// Throughput: one byte per cycle while results drain; only a header's last byte
// yields a result. Rate is set by the single result register, refilled as it drains.
// Reset (rst_n, async, active low): parser waits for a first header byte,
// error flag cleared, size limit back to 15728640, result register empty.
module websocket_frame_deframer (
    input  logic          clk,
    input  logic          rst_n,
    wsd_byte_if.sink      rx,
    wsd_cfg_if.sink       cfg,
    wsd_res_if.source     res
);
    import wsd_pkg::*;

    logic        res_load;
    logic        rx_ready;
    logic        res_valid;
    wsd_result_t res_next;
    wsd_result_t res_data;

    // byte transfers are held off only while an unread result sits in the
    // output register; bytes after a framing error are still taken and dropped
    assign rx.ready  = rx_ready;
    // limit register can be written at any time; it is only sampled on the
    // byte that completes the length
    assign cfg.ready = 1'b1;

    wsd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx.valid),
        .rx_byte   (rx.in_byte),
        .rx_ready  (rx_ready),
        .cfg_valid (cfg.valid),
        .cfg_data  (cfg.size_limit),
        .res_load  (res_load),
        .res_data  (res_next)
    );

    // single result stage: parts the byte side from the result side
    wsd_out_reg u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (res_load),
        .din   (res_next),
        .take  (res.ready),
        .valid (res_valid),
        .dout  (res_data),
        .ready (rx_ready)
    );

    assign res.valid        = res_valid;
    assign res.kind         = res_data.kind;
    assign res.fin_flag     = res_data.fin_flag;
    assign res.opcode       = res_data.opcode;
    assign res.was_masked   = res_data.was_masked;
    assign res.frame_length = res_data.frame_length;
    assign res.payload_byte = res_data.payload_byte;
    assign res.last         = res_data.last;
    assign res.error_code   = res_data.error_code;

endmodule

@@ hw/rtl/wsd_checker.sv @@
module wsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [1:0]  res_kind,
    input logic [7:0]  res_payload_byte,
    input logic        res_last,
    input logic [1:0]  res_error_code
);
    import wsd_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_payload_byte)
            && $stable(res_kind))
        else $error("stalled result changed");

    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_ERROR |-> res_error_code != ERR_NONE && !res_last)
        else $error("error result malformed");

    a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind != KIND_ERROR |-> res_error_code == ERR_NONE)
        else $error("error code on a normal result");

    a_hdr_byte: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind != KIND_PAYLOAD |-> res_payload_byte == 8'd0)
        else $error("payload byte on a non-payload result");

    // after an error transfer the stream is dead until reset
    a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && res_kind == KIND_ERROR |=> !res_valid)
        else $error("result after framing error");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .res_kind         (res.kind),
    .res_payload_byte (res.payload_byte),
    .res_last         (res.last),
    .res_error_code   (res.error_code)
);

@@ dv/websocket_frame_deframer_test.sv @@
module websocket_frame_deframer_test;
    import wsd_pkg::*;

    // Parser phases of the local frame tracker
    typedef enum logic [4:0] {
        AWAIT_HDR0    = 5'b00001,
        AWAIT_HDR1    = 5'b00010,
        AWAIT_EXTLEN  = 5'b00100,
        AWAIT_KEY     = 5'b01000,
        AWAIT_PAYLOAD = 5'b10000
    } parse_phase_t;

    // How the payload length is carried on the wire
    typedef enum logic [1:0] {
        FORM_SHORT,
        FORM_EXT16,
        FORM_EXT64
    } len_form_t;

    // Receiver behaviour between long hold-offs
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_SELDOM,
        READY_ALTERNATE
    } ready_style_t;

    // How the run is brought to its final, latched state
    typedef enum logic [1:0] {
        END_OVER_LIMIT,
        END_WIDE_LENGTH,
        END_EMPTY_DATA,
        END_NOISE
    } end_style_t;

    localparam logic [3:0] OP_CONT      = 4'h0;
    localparam logic [3:0] OP_CLOSE     = 4'h8;
    localparam logic [3:0] OP_PING      = 4'h9;
    localparam logic [3:0] OP_PONG      = 4'hA;
    localparam logic [3:0] OP_RSVD_TOP  = 4'hF;

    localparam int QUIET_LIMIT  = 2000;  // cycles with no transfer of any kind
    localparam int DRAIN_CYCLES = 4;     // covers the registered result, plus margin

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    wsd_byte_if rx ();
    wsd_cfg_if  cfg ();
    wsd_res_if  res ();

    websocket_frame_deframer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .cfg   (cfg),
        .res   (res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Local frame tracker: mirrors the deframer state, one byte at a time
    // ------------------------------------------------------------------
    parse_phase_t           pr_phase    = AWAIT_HDR0;
    logic                   pr_fin      = 1'b0;
    logic [3:0]             pr_opcode   = 4'h0;
    logic                   pr_masked   = 1'b0;
    logic [63:0]            pr_len      = '0;
    logic [3:0]             pr_hdr_left = '0;
    logic [31:0]            pr_key      = '0;
    logic [1:0]             pr_key_idx  = '0;
    logic [FRAME_LEN_W-1:0] pr_left     = '0;
    logic                   pr_error    = 1'b0;
    logic [FRAME_LEN_W-1:0] frame_limit = MAX_FRAME_RESET;

    logic [7:0]  pending_bytes[$];   // bytes still to be offered
    wsd_result_t results_due[$];     // deframer results not yet seen

    int bytes_planned  = 0;
    int bytes_taken    = 0;
    int bytes_ignored  = 0;
    int headers_seen   = 0;
    int payloads_seen  = 0;
    int errors_seen    = 0;
    int limits_set     = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;

    int burst_left = 0;
    int gap_left   = 0;

    int           hold_left      = 0;
    int           style_left     = 0;
    ready_style_t stall_style    = READY_ALWAYS;
    bit           long_hold_done = 1'b0;
    bit           bulk_phase     = 1'b0;

    function automatic void post_result(input logic [1:0] kind, input logic [63:0] len,
                                        input logic [7:0] data, input logic is_last,
                                        input logic [1:0] code);
        wsd_result_t r;
        r.kind         = kind;
        r.fin_flag     = pr_fin;
        r.opcode       = pr_opcode;
        r.was_masked   = pr_masked;
        // lengths wider than the result field saturate
        r.frame_length = (len > 64'(FRAME_LEN_SAT)) ? FRAME_LEN_SAT : len[FRAME_LEN_W-1:0];
        r.payload_byte = data;
        r.last         = is_last;
        r.error_code   = code;
        results_due.push_back(r);
    endfunction

    // Header and key are in: report the header, then go to payload or next frame
    function automatic void close_header();
        logic empty;
        empty = (pr_len == '0);
        post_result(KIND_HEADER, pr_len, 8'h00, empty, ERR_NONE);
        pr_key_idx = '0;
        if (empty)
        begin
            pr_phase = AWAIT_HDR0;
        end
        else
        begin
            pr_left  = pr_len[FRAME_LEN_W-1:0];
            pr_phase = AWAIT_PAYLOAD;
        end
    endfunction

    // Length complete: size and empty-frame checks come before any key byte
    function automatic void check_length();
        logic [1:0] code;
        code = ERR_NONE;
        if (pr_len > 64'(frame_limit) || pr_len > 64'(FRAME_LEN_SAT))
            code = ERR_OVERSIZE;
        else if (pr_len == '0 && (pr_opcode == OP_TEXT || pr_opcode == OP_BINARY))
            code = ERR_EMPTY;

        if (code != ERR_NONE)
        begin
            post_result(KIND_ERROR, pr_len, 8'h00, 1'b0, code);
            pr_error = 1'b1;
            pr_phase = AWAIT_HDR0;
        end
        else if (pr_masked)
        begin
            pr_hdr_left = KEY_BYTES;
            pr_key      = '0;
            pr_phase    = AWAIT_KEY;
        end
        else
        begin
            pr_key = '0;
            close_header();
        end
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        logic [7:0] key_byte;
        logic [6:0] len7;
        if (pr_error)
        begin
            bytes_ignored++;
            return;
        end
        case (pr_phase)
            AWAIT_HDR1:
            begin
                pr_masked = b[7];
                len7      = b[6:0];
                pr_len    = '0;
                if (len7 == LEN7_EXT16)
                begin
                    pr_hdr_left = EXT16_BYTES;
                    pr_phase    = AWAIT_EXTLEN;
                end
                else if (len7 == LEN7_EXT64)
                begin
                    pr_hdr_left = EXT64_BYTES;
                    pr_phase    = AWAIT_EXTLEN;
                end
                else
                begin
                    pr_len = 64'(len7);
                    check_length();
                end
            end
            AWAIT_EXTLEN:
            begin
                // big-endian extension
                pr_len      = {pr_len[55:0], b};
                pr_hdr_left = pr_hdr_left - 4'd1;
                if (pr_hdr_left == '0)
                    check_length();
            end
            AWAIT_KEY:
            begin
                pr_key      = {pr_key[23:0], b};
                pr_hdr_left = pr_hdr_left - 4'd1;
                if (pr_hdr_left == '0)
                    close_header();
            end
            AWAIT_PAYLOAD:
            begin
                // first key byte on the wire masks payload byte 0
                key_byte   = pr_masked ? pr_key[31 - 8*pr_key_idx -: 8] : 8'h00;
                pr_key_idx = pr_key_idx + 2'd1;
                pr_left    = pr_left - FRAME_LEN_W'(1);
                post_result(KIND_PAYLOAD, pr_len, b ^ key_byte, pr_left == '0, ERR_NONE);
                if (pr_left == '0)
                    pr_phase = AWAIT_HDR0;
            end
            default:
            begin
                // RSV bits are not looked at
                pr_fin    = b[7];
                pr_opcode = b[3:0];
                pr_phase  = AWAIT_HDR1;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Frame builders
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        bytes_planned++;
    endtask

    // Header, length extension, key if masked, then payload_n random bytes
    task automatic queue_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                               input logic masked, input len_form_t form,
                               input logic [63:0] len, input int payload_n);
        push_byte({fin, rsv, op});
        case (form)
            FORM_EXT16:
            begin
                push_byte({masked, LEN7_EXT16});
                push_byte(len[15:8]);
                push_byte(len[7:0]);
            end
            FORM_EXT64:
            begin
                push_byte({masked, LEN7_EXT64});
                for (int i = 7; i >= 0; i--)
                    push_byte(len[8*i +: 8]);
            end
            default:
                push_byte({masked, len[6:0]});
        endcase
        if (masked)
            repeat (KEY_BYTES) push_byte(8'($urandom));
        repeat (payload_n) push_byte(8'($urandom));
    endtask

    // Well-formed frame that stays inside the current size limit
    task automatic queue_random_frame();
        logic [3:0]  op;
        int unsigned cap;
        int unsigned len;
        int unsigned pick;
        len_form_t   form;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2: op = OP_TEXT;
            3, 4:    op = OP_BINARY;
            5:       op = OP_CONT;
            6:       op = OP_CLOSE;
            7:       op = OP_PING;
            8:       op = OP_PONG;
            // reserved: 3..7 or 11..15
            default: op = 4'($urandom_range(3, 7)) | ($urandom_range(0, 1) ? 4'h8 : 4'h0);
        endcase

        // mostly short frames, now and then a few hundred bytes
        cap  = (frame_limit < 300) ? frame_limit : 300;
        pick = $urandom_range(0, 15);
        if (pick < 10)
            len = $urandom_range(0, (cap < 12) ? cap : 12);
        else if (pick < 14)
            len = $urandom_range(0, (cap < 60) ? cap : 60);
        else
            len = $urandom_range(0, cap);

        if (len == 0 && (op == OP_TEXT || op == OP_BINARY))
        begin
            if (cap == 0)
                op = OP_PING;
            else
                len = 1;
        end

        if (len > 125)
        begin
            form = $urandom_range(0, 1) ? FORM_EXT16 : FORM_EXT64;
        end
        else
        begin
            pick = $urandom_range(0, 4);
            form = (pick < 3) ? FORM_SHORT : ((pick == 3) ? FORM_EXT16 : FORM_EXT64);
        end

        queue_frame(1'($urandom_range(0, 1)),
                    ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'b000,
                    op, 1'($urandom_range(0, 1)), form, 64'(len), len);
    endtask

    // Sender holds back until the deframer has nothing left to report
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || rx.valid || results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Only ever called with the deframer idle
    task automatic set_frame_limit(input logic [FRAME_LEN_W-1:0] value);
        @(posedge clk);
        cfg.valid      <= 1'b1;
        cfg.size_limit <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid   <= 1'b0;
        frame_limit = value;
        limits_set++;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [FRAME_LEN_W-1:0] lim;
        int                     target;
        logic [63:0]            wide_len;
        end_style_t             ending;

        cfg.valid      = 1'b0;
        cfg.size_limit = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frames under the reset size limit
        // unmasked text, payload at both byte extremes
        queue_frame(1'b1, 3'b000, OP_TEXT, 1'b0, FORM_SHORT, 64'd3, 0);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'hA5);
        // masked binary, 16-bit length: checks key byte order
        queue_frame(1'b1, 3'b000, OP_BINARY, 1'b1, FORM_EXT16, 64'd4, 4);
        // masked empty ping: key still consumed, header marked last
        queue_frame(1'b1, 3'b000, OP_PING, 1'b1, FORM_SHORT, 64'd0, 0);
        // reserved opcode, all RSV bits set, 64-bit length, not final
        queue_frame(1'b0, 3'b111, OP_RSVD_TOP, 1'b0, FORM_EXT64, 64'd1, 1);
        // unmasked empty close
        queue_frame(1'b1, 3'b000, OP_CLOSE, 1'b0, FORM_SHORT, 64'd0, 0);
        wait_drained();

        // Widest limit; the sender pauses for a full drain half-way
        set_frame_limit(FRAME_LEN_SAT);
        bulk_phase = 1'b1;
        target     = bytes_planned + 170;
        while (bytes_planned < target)
            queue_random_frame();
        wait_drained();
        target = bytes_planned + 170;
        while (bytes_planned < target)
            queue_random_frame();
        wait_drained();

        // Zero limit: only empty frames get through, none of them text or binary
        set_frame_limit('0);
        target = bytes_planned + 80;
        while (bytes_planned < target)
            queue_random_frame();
        wait_drained();

        // Small limit, with one frame sitting exactly on it
        lim = FRAME_LEN_W'($urandom_range(1, 60));
        set_frame_limit(lim);
        queue_frame(1'b1, 3'b000, OP_BINARY, 1'($urandom_range(0, 1)), FORM_EXT16,
                    64'(lim), lim);
        target = bytes_planned + 340;
        while (bytes_planned < target)
            queue_random_frame();
        wait_drained();
        bulk_phase = 1'b0;

        // An error latches for good, so exactly one error path is run, last
        ending = end_style_t'($urandom_range(0, 3));
        case (ending)
            END_OVER_LIMIT:
            begin
                lim = FRAME_LEN_W'($urandom_range(1, 200));
                set_frame_limit(lim);
                queue_frame(1'($urandom_range(0, 1)), 3'b000, 4'($urandom),
                            1'($urandom_range(0, 1)), FORM_EXT16, 64'(lim) + 64'd1, 0);
            end
            END_WIDE_LENGTH:
            begin
                // length beyond the 24-bit range; reported length saturates
                set_frame_limit(FRAME_LEN_SAT);
                wide_len = {$urandom, $urandom} | (64'd1 << $urandom_range(24, 63));
                queue_frame(1'b1, 3'b000, 4'($urandom), 1'($urandom_range(0, 1)),
                            FORM_EXT64, wide_len, 0);
            end
            END_EMPTY_DATA:
            begin
                queue_frame(1'b1, 3'b000, $urandom_range(0, 1) ? OP_TEXT : OP_BINARY,
                            1'($urandom_range(0, 1)), FORM_SHORT, 64'd0, 0);
            end
            default:
            begin
                // raw noise; the tracker follows whatever framing results
                repeat (80) push_byte(8'($urandom));
            end
        endcase
        // trailing bytes: should be dropped once the error has latched
        repeat (24) push_byte(8'($urandom));
        wait_drained();
        repeat (8) @(posedge clk);

        $display("Run: %0d bytes transferred (%0d dropped after a latched error), %0d limit writes.",
                 bytes_taken, bytes_ignored, limits_set);
        $display("Results: %0d headers, %0d payload bytes, %0d errors; %0d mismatches.",
                 headers_seen, payloads_seen, errors_seen, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Byte sender: bursts of random length, random gaps in between.
    // Each accepted transfer is fed to the tracker at the same edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : byte_sender
        if (!rst_n)
        begin
            rx.valid   <= 1'b0;
            rx.in_byte <= '0;
        end
        else
        begin
            if (rx.valid && rx.ready)
            begin
                deframe_byte(rx.in_byte);
                bytes_taken++;
            end
            // hold the byte on the bus until it is taken
            if (!rx.valid || rx.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    rx.valid <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    rx.valid   <= 1'b1;
                    rx.in_byte <= pending_bytes.pop_front();
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 32);
                        // a third of bursts run straight into the next
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    rx.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: stall pattern of its own, plus long hold-offs.
    // The first long hold-off lands while bytes are still being offered,
    // so the result register fills and the byte input backs up.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_sink
        if (!rst_n)
        begin
            res.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            res.ready <= 1'b0;
        end
        else if ((bulk_phase && rx.valid && !long_hold_done) || $urandom_range(0, 999) == 0)
        begin
            long_hold_done = 1'b1;
            hold_left      = $urandom_range(60, 120);
            res.ready <= 1'b0;
        end
        else
        begin
            if (style_left == 0)
            begin
                stall_style = ready_style_t'($urandom_range(0, 3));
                style_left  = $urandom_range(16, 96);
            end
            else
            begin
                style_left--;
            end
            case (stall_style)
                READY_ALWAYS: res.ready <= 1'b1;
                READY_MOSTLY: res.ready <= ($urandom_range(0, 3) != 0);
                READY_SELDOM: res.ready <= ($urandom_range(0, 3) == 0);
                default:      res.ready <= style_left[1];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each transfer against the oldest result due
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [23:0] want,
                                        input logic [23:0] got);
        if (got !== want)
        begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        wsd_result_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (results_due.size() == 0)
            begin
                $error("unexpected result transfer: kind %0d", res.kind);
                mismatches++;
            end
            else
            begin
                want = results_due.pop_front();
                check_field("kind",         24'(want.kind),       24'(res.kind));
                check_field("fin_flag",     24'(want.fin_flag),   24'(res.fin_flag));
                check_field("opcode",       24'(want.opcode),     24'(res.opcode));
                check_field("was_masked",   24'(want.was_masked), 24'(res.was_masked));
                check_field("frame_length", want.frame_length,    res.frame_length);
                check_field("payload_byte", 24'(want.payload_byte), 24'(res.payload_byte));
                check_field("last",         24'(want.last),       24'(res.last));
                check_field("error_code",   24'(want.error_code), 24'(res.error_code));
                case (want.kind)
                    KIND_HEADER:  headers_seen++;
                    KIND_PAYLOAD: payloads_seen++;
                    default:      errors_seen++;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transfer ends the run
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((rx.valid && rx.ready) || (res.valid && res.ready) ||
                (cfg.valid && cfg.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $error("no transfer for %0d cycles, %0d results still due",
                       quiet_cycles, results_due.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

endmodule
